// ===== src/bfic_pkg.sv =====
// Shared types and constants for the instruction coalescer.
package bfic_pkg;

    localparam int DEF_NEST_DEPTH   = 64;
    localparam int DEF_AMOUNT_WIDTH = 16;
    localparam int DEF_LABEL_WIDTH  = 16;

    localparam int SYMBOL_W = 8;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;

    localparam logic [SYMBOL_W-1:0] CH_RIGHT = 8'h3E;  // '>'
    localparam logic [SYMBOL_W-1:0] CH_LEFT  = 8'h3C;  // '<'
    localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [SYMBOL_W-1:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [SYMBOL_W-1:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [SYMBOL_W-1:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [SYMBOL_W-1:0] CH_CLOSE = 8'h5D;  // ']'

    typedef enum logic [OP_W-1:0] {
        OP_NONE  = 3'd0,
        OP_MOVE  = 3'd1,
        OP_ADD   = 3'd2,
        OP_OUT   = 3'd3,
        OP_IN    = 3'd4,
        OP_OPEN  = 3'd5,
        OP_CLOSE = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_CODE   = 3'd1,
        ST_UNCLOSED  = 3'd2,
        ST_UNMATCHED = 3'd3,
        ST_TOO_DEEP  = 3'd4,
        ST_LABEL_OVF = 3'd5
    } t_status;

    typedef struct packed {
        logic store;
        logic reload;
        logic load;
    } t_cache_flags;

endpackage

// ===== src/bfic_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfic_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/bfic_core.sv =====
// Command decode, run merging, cache flags, loop label stack and error tracking.
module bfic_core #(
    parameter int NEST_DEPTH   = bfic_pkg::DEF_NEST_DEPTH,
    parameter int AMOUNT_WIDTH = bfic_pkg::DEF_AMOUNT_WIDTH,
    parameter int LABEL_WIDTH  = bfic_pkg::DEF_LABEL_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [bfic_pkg::SYMBOL_W-1:0]   i_symbol,
    input  logic                            i_end,
    output logic                            o_res_valid,
    output bfic_pkg::t_op                   o_res_op,
    output logic signed [AMOUNT_WIDTH-1:0]  o_res_amount,
    output logic [LABEL_WIDTH-1:0]          o_res_label,
    output bfic_pkg::t_cache_flags          o_res_flags,
    output bfic_pkg::t_status               o_res_status,
    output logic                            o_res_last
);

    localparam int TOP_W  = $clog2(NEST_DEPTH + 1);
    localparam int ADDR_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    localparam logic signed [AMOUNT_WIDTH-1:0] AMT_MAX = {1'b0, {(AMOUNT_WIDTH-1){1'b1}}};
    localparam logic signed [AMOUNT_WIDTH-1:0] AMT_MIN = {1'b1, {(AMOUNT_WIDTH-1){1'b0}}};
    localparam logic signed [AMOUNT_WIDTH-1:0] AMT_ONE = AMOUNT_WIDTH'(1);
    localparam logic signed [AMOUNT_WIDTH-1:0] AMT_NEG = {AMOUNT_WIDTH{1'b1}};
    localparam logic [LABEL_WIDTH-1:0]         LABEL_MAX = {LABEL_WIDTH{1'b1}};

    // pending instruction and program state
    bfic_pkg::t_op                  r_op, n_op;
    logic signed [AMOUNT_WIDTH-1:0] r_amt, n_amt;
    logic [LABEL_WIDTH-1:0]         r_label, n_label;
    bfic_pkg::t_cache_flags         r_need, n_need;
    logic [TOP_W-1:0]               r_top, n_top;
    logic [LABEL_WIDTH-1:0]         r_tos, n_tos;
    logic [LABEL_WIDTH-1:0]         r_next_label, n_next_label;
    bfic_pkg::t_status              r_err, n_err;
    logic                           r_byp;
    logic [LABEL_WIDTH-1:0]         r_byp_data;

    // emit side of the pending instruction
    bfic_pkg::t_cache_flags         use_flags;
    bfic_pkg::t_cache_flags         base_flags;
    logic                           pend_any;
    logic                           is_amt_op;
    logic                           is_loop_op;

    // decode intents
    logic                           do_flush;
    logic                           run_sel;
    bfic_pkg::t_op                  run_op;
    logic                           run_up;
    logic                           set_store;
    logic                           set_reload;
    logic                           set_load;
    logic                           clr_store;
    logic                           push;

    // stack spill memory holds every entry below the top
    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [ADDR_W-1:0]              rd_addr;
    logic [LABEL_WIDTH-1:0]         rd_data;
    logic [LABEL_WIDTH-1:0]         below;
    logic [TOP_W-1:0]               top_m1;
    logic [TOP_W-1:0]               ntop_m2;

    assign pend_any   = (r_op != bfic_pkg::OP_NONE);
    assign is_amt_op  = (r_op == bfic_pkg::OP_MOVE) || (r_op == bfic_pkg::OP_ADD);
    assign is_loop_op = (r_op == bfic_pkg::OP_OPEN) || (r_op == bfic_pkg::OP_CLOSE);

    always_comb begin
        use_flags.store  = r_need.store & ((r_op == bfic_pkg::OP_MOVE) ||
                           (r_op == bfic_pkg::OP_OUT) || is_loop_op);
        use_flags.reload = r_need.reload & ((r_op == bfic_pkg::OP_ADD) ||
                           (r_op == bfic_pkg::OP_OUT) || (r_op == bfic_pkg::OP_IN) ||
                           is_loop_op);
        use_flags.load   = r_need.load & ((r_op == bfic_pkg::OP_ADD) || is_loop_op);
    end

    always_comb begin
        run_sel    = 1'b0;
        run_op     = bfic_pkg::OP_NONE;
        run_up     = 1'b0;
        do_flush   = 1'b0;
        set_store  = 1'b0;
        set_reload = 1'b0;
        set_load   = 1'b0;
        clr_store  = 1'b0;
        push       = 1'b0;
        n_op         = r_op;
        n_amt        = r_amt;
        n_label      = r_label;
        n_next_label = r_next_label;
        n_err        = r_err;
        n_top        = r_top;
        n_tos        = r_tos;

        if (i_valid && !i_end && (r_err == bfic_pkg::ST_OK)) begin
            case (i_symbol)
                bfic_pkg::CH_RIGHT: begin
                    run_sel = 1'b1; run_op = bfic_pkg::OP_MOVE; run_up = 1'b1;
                end
                bfic_pkg::CH_LEFT: begin
                    run_sel = 1'b1; run_op = bfic_pkg::OP_MOVE; run_up = 1'b0;
                end
                bfic_pkg::CH_PLUS: begin
                    run_sel = 1'b1; run_op = bfic_pkg::OP_ADD; run_up = 1'b1;
                end
                bfic_pkg::CH_MINUS: begin
                    run_sel = 1'b1; run_op = bfic_pkg::OP_ADD; run_up = 1'b0;
                end
                bfic_pkg::CH_DOT: begin
                    do_flush = 1'b1;
                    n_op     = bfic_pkg::OP_OUT;
                end
                bfic_pkg::CH_COMMA: begin
                    do_flush  = 1'b1;
                    n_op      = bfic_pkg::OP_IN;
                    set_load  = 1'b1;
                    clr_store = 1'b1;
                end
                bfic_pkg::CH_OPEN: begin
                    if (r_top == TOP_W'(NEST_DEPTH)) begin
                        n_err = bfic_pkg::ST_TOO_DEEP;
                    end else if (r_next_label == LABEL_MAX) begin
                        n_err = bfic_pkg::ST_LABEL_OVF;
                    end else begin
                        do_flush     = 1'b1;
                        push         = 1'b1;
                        n_op         = bfic_pkg::OP_OPEN;
                        n_label      = r_next_label;
                        n_tos        = r_next_label;
                        n_top        = r_top + TOP_W'(1);
                        n_next_label = r_next_label + LABEL_WIDTH'(1);
                    end
                end
                bfic_pkg::CH_CLOSE: begin
                    if (r_top == '0) begin
                        n_err = bfic_pkg::ST_UNMATCHED;
                    end else begin
                        do_flush = 1'b1;
                        n_op     = bfic_pkg::OP_CLOSE;
                        n_label  = r_tos;
                        n_top    = r_top - TOP_W'(1);
                        if (r_top > TOP_W'(1)) begin
                            n_tos = below;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (run_sel) begin
            if (r_op == run_op) begin
                if (run_up && (r_amt != AMT_MAX)) begin
                    n_amt = r_amt + AMT_ONE;
                end else if (!run_up && (r_amt != AMT_MIN)) begin
                    n_amt = r_amt - AMT_ONE;
                end
            end else begin
                do_flush = 1'b1;
                n_op     = run_op;
                n_amt    = run_up ? AMT_ONE : AMT_NEG;
                if (run_op == bfic_pkg::OP_MOVE) begin
                    set_load   = 1'b1;
                    set_reload = 1'b1;
                end else begin
                    set_store  = 1'b1;
                end
            end
        end

        // flags consumed by the emitted instruction clear before the new op sets its own
        base_flags.store  = do_flush ? (r_need.store  & ~use_flags.store)  : r_need.store;
        base_flags.reload = do_flush ? (r_need.reload & ~use_flags.reload) : r_need.reload;
        base_flags.load   = do_flush ? (r_need.load   & ~use_flags.load)   : r_need.load;
        n_need.store  = (base_flags.store | set_store) & ~clr_store;
        n_need.reload = base_flags.reload | set_reload;
        n_need.load   = base_flags.load | set_load;

        o_res_valid  = i_valid && (i_end || (do_flush && pend_any));
        o_res_op     = r_op;
        o_res_amount = is_amt_op ? r_amt : '0;
        o_res_label  = is_loop_op ? r_label : '0;
        o_res_flags  = use_flags;
        o_res_status = r_err;
        o_res_last   = i_end;

        if (i_valid && i_end) begin
            if (r_err == bfic_pkg::ST_OK) begin
                if (!pend_any) begin
                    o_res_status = bfic_pkg::ST_NO_CODE;
                end else if (r_top != '0) begin
                    o_res_status = bfic_pkg::ST_UNCLOSED;
                end
            end
            // program done: back to the reset state
            n_op         = bfic_pkg::OP_NONE;
            n_amt        = '0;
            n_label      = '0;
            n_need       = '0;
            n_top        = '0;
            n_next_label = '0;
            n_err        = bfic_pkg::ST_OK;
        end
    end

    // read address follows the next top so the entry under it is ready for a pop
    assign top_m1  = r_top - TOP_W'(1);
    assign ntop_m2 = n_top - TOP_W'(2);
    assign wr_en   = push && (r_top != '0);
    assign wr_addr = top_m1[ADDR_W-1:0];
    assign rd_addr = ntop_m2[ADDR_W-1:0];
    assign below   = r_byp ? r_byp_data : rd_data;

    bfic_ram #(
        .WIDTH (LABEL_WIDTH),
        .DEPTH (NEST_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_tos),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op         <= bfic_pkg::OP_NONE;
            r_need       <= '0;
            r_top        <= '0;
            r_next_label <= '0;
            r_err        <= bfic_pkg::ST_OK;
            r_byp        <= 1'b0;
        end else begin
            r_op         <= n_op;
            r_need       <= n_need;
            r_top        <= n_top;
            r_next_label <= n_next_label;
            r_err        <= n_err;
            r_byp        <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_amt      <= n_amt;
        r_label    <= n_label;
        r_tos      <= n_tos;
        r_byp_data <= r_tos;
    end

endmodule

// ===== src/bfic_out_buf.sv =====
// Output register with a one-entry skid stage.
module bfic_out_buf #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_data;
    logic             r_sk_valid;
    logic [WIDTH-1:0] r_sk_data;
    logic             out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_sk_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_sk_valid || i_valid;
            r_sk_valid  <= 1'b0;
        end else if (i_valid) begin
            r_sk_valid  <= 1'b1;
        end
    end

    // no new request is taken while the skid is full, so it drains first
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_sk_valid ? r_sk_data : i_data;
        end else if (i_valid) begin
            r_sk_data <= i_data;
        end
    end

endmodule

// ===== src/bf_instruction_coalescer.sv =====
// A flushed instruction is registered in the output stage, or in the skid stage under a stall.
// Throughput: one source byte per cycle while o_s_tready is high.
// o_s_tready drops only while the skid stage holds a result that the sink has not taken.
// Reset (i_rst_n, synchronous, active low) clears program state and output valids at once.
// The label stack memory is not cleared; only entries below the stack top are ever used.
module bf_instruction_coalescer #(
    parameter int NEST_DEPTH   = bfic_pkg::DEF_NEST_DEPTH,
    parameter int AMOUNT_WIDTH = bfic_pkg::DEF_AMOUNT_WIDTH,
    parameter int LABEL_WIDTH  = bfic_pkg::DEF_LABEL_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  logic [bfic_pkg::SYMBOL_W-1:0] i_s_tdata,   // symbol
    input  logic i_s_tlast,                             // end_marker
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // amount, label, store_before, reload_pointer, load_after, status, zero pad
    output logic [((AMOUNT_WIDTH + LABEL_WIDTH + 6 + 7) / 8) * 8 - 1:0] o_m_tdata,
    output logic [bfic_pkg::OP_W-1:0] o_m_tuser,        // op
    output logic o_m_tlast                              // last
);

    localparam int FIELD_W = AMOUNT_WIDTH + LABEL_WIDTH + 3 + bfic_pkg::STATUS_W;
    localparam int TDATA_W = ((AMOUNT_WIDTH + LABEL_WIDTH + 6 + 7) / 8) * 8;
    localparam int BUF_W   = TDATA_W + bfic_pkg::OP_W + 1;

    logic                           in_fire;
    logic                           res_valid;
    bfic_pkg::t_op                  res_op;
    logic signed [AMOUNT_WIDTH-1:0] res_amount;
    logic [LABEL_WIDTH-1:0]         res_label;
    bfic_pkg::t_cache_flags         res_flags;
    bfic_pkg::t_status              res_status;
    logic                           res_last;
    logic [TDATA_W-1:0]             res_tdata;
    logic [FIELD_W-1:0]             res_fields;
    logic [BUF_W-1:0]               buf_in;
    logic [BUF_W-1:0]               buf_out;

    assign in_fire = i_s_tvalid && o_s_tready;

    bfic_core #(
        .NEST_DEPTH   (NEST_DEPTH),
        .AMOUNT_WIDTH (AMOUNT_WIDTH),
        .LABEL_WIDTH  (LABEL_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_fire),
        .i_symbol     (i_s_tdata),
        .i_end        (i_s_tlast),
        .o_res_valid  (res_valid),
        .o_res_op     (res_op),
        .o_res_amount (res_amount),
        .o_res_label  (res_label),
        .o_res_flags  (res_flags),
        .o_res_status (res_status),
        .o_res_last   (res_last)
    );

    assign res_fields = {res_status, res_flags.load, res_flags.reload, res_flags.store,
                         res_label, res_amount};
    // zero pad up to whole bytes
    assign res_tdata  = TDATA_W'(res_fields);
    assign buf_in     = {res_last, res_op, res_tdata};

    bfic_out_buf #(
        .WIDTH (BUF_W)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (buf_in),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (buf_out)
    );

    assign o_m_tdata = buf_out[TDATA_W-1:0];
    assign o_m_tuser = buf_out[TDATA_W +: bfic_pkg::OP_W];
    assign o_m_tlast = buf_out[BUF_W-1];

endmodule

// ===== test/bf_instruction_coalescer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bf_instruction_coalescer against a local predictor.
module bf_instruction_coalescer_tb;

    localparam int NEST           = bfic_pkg::DEF_NEST_DEPTH;
    localparam int AMT_W          = bfic_pkg::DEF_AMOUNT_WIDTH;
    localparam int LAB_W          = bfic_pkg::DEF_LABEL_WIDTH;
    localparam int SYM_W          = bfic_pkg::SYMBOL_W;
    localparam int DATA_W         = ((AMT_W + LAB_W + 6 + 7) / 8) * 8;
    localparam int STORE_BIT      = AMT_W + LAB_W;
    localparam int STATUS_LSB     = STORE_BIT + 3;
    localparam int RANDOM_ITEMS   = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;

    localparam logic signed [AMT_W-1:0] AMT_MAX    = {1'b0, {(AMT_W-1){1'b1}}};
    localparam logic signed [AMT_W-1:0] AMT_MIN    = {1'b1, {(AMT_W-1){1'b0}}};
    localparam logic [LAB_W-1:0]        LABEL_LAST = {LAB_W{1'b1}};

    typedef struct {
        bfic_pkg::t_op           op;
        logic signed [AMT_W-1:0] amount;
        logic [LAB_W-1:0]        label;
        bfic_pkg::t_cache_flags  flags;
        bfic_pkg::t_status       status;
        logic                    last;
    } t_instr;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_tvalid;
    logic                      o_s_tready;
    logic [SYM_W-1:0]          i_s_tdata;   // symbol
    logic                      i_s_tlast;   // end marker
    logic                      o_m_tvalid;
    logic                      i_m_tready;
    logic [DATA_W-1:0]         o_m_tdata;   // amount, label, store, reload, load, status, pad
    logic [bfic_pkg::OP_W-1:0] o_m_tuser;   // op
    logic                      o_m_tlast;   // last

    bf_instruction_coalescer #(
        .NEST_DEPTH   (NEST),
        .AMOUNT_WIDTH (AMT_W),
        .LABEL_WIDTH  (LAB_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Predictor state for the program being coalesced
    bfic_pkg::t_op           cur_op;
    logic signed [AMT_W-1:0] cur_amount;
    logic [LAB_W-1:0]        cur_label;
    bfic_pkg::t_cache_flags  want;
    logic [LAB_W-1:0]        open_labels [NEST];
    int                      open_depth;
    logic [LAB_W-1:0]        label_next;
    bfic_pkg::t_status       prog_error;
    t_instr                  expected_instrs [$];

    int requests_sent     = 0;
    int results_checked   = 0;
    int programs_done     = 0;
    int flagged_programs  = 0;
    int mismatches        = 0;
    int idle_cycles       = 0;
    int sink_hold         = 0;
    bit sink_stalls       = 1'b1;
    bit src_gaps          = 1'b1;

    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic void clear_program();
        cur_op     = bfic_pkg::OP_NONE;
        cur_amount = '0;
        cur_label  = '0;
        want       = '0;
        open_depth = 0;
        label_next = '0;
        prog_error = bfic_pkg::ST_OK;
    endfunction

    // Hand out the held instruction; the cache flags it consumes are cleared.
    function automatic void release_pending(bfic_pkg::t_status st, logic last);
        bfic_pkg::t_cache_flags uses;
        t_instr                 e;
        uses = '0;
        case (cur_op)
            bfic_pkg::OP_MOVE: uses.store = 1'b1;
            bfic_pkg::OP_ADD: begin
                uses.reload = 1'b1;
                uses.load   = 1'b1;
            end
            bfic_pkg::OP_OUT: begin
                uses.store  = 1'b1;
                uses.reload = 1'b1;
            end
            bfic_pkg::OP_IN: uses.reload = 1'b1;
            bfic_pkg::OP_OPEN, bfic_pkg::OP_CLOSE: uses = '1;
            default: if (!last) return;
        endcase
        uses     = uses & want;
        want     = want & ~uses;
        e.op     = cur_op;
        e.amount = (cur_op == bfic_pkg::OP_MOVE || cur_op == bfic_pkg::OP_ADD) ?
                   cur_amount : '0;
        e.label  = (cur_op == bfic_pkg::OP_OPEN || cur_op == bfic_pkg::OP_CLOSE) ?
                   cur_label : '0;
        e.flags  = uses;
        e.status = st;
        e.last   = last;
        expected_instrs.push_back(e);
    endfunction

    function automatic void merge_run(bfic_pkg::t_op op, bit up);
        if (cur_op == op) begin
            if (up && cur_amount != AMT_MAX) cur_amount++;
            else if (!up && cur_amount != AMT_MIN) cur_amount--;
        end else begin
            release_pending(prog_error, 1'b0);
            cur_op     = op;
            cur_amount = up ? AMT_W'(1) : AMT_W'(-1);
            if (op == bfic_pkg::OP_MOVE) begin
                want.load   = 1'b1;
                want.reload = 1'b1;
            end else begin
                want.store = 1'b1;
            end
        end
    endfunction

    function automatic void coalesce_request(logic [SYM_W-1:0] sym, logic endm);
        bfic_pkg::t_status st;
        if (endm) begin
            st = prog_error;
            if (st == bfic_pkg::ST_OK) begin
                if (cur_op == bfic_pkg::OP_NONE) st = bfic_pkg::ST_NO_CODE;
                else if (open_depth != 0) st = bfic_pkg::ST_UNCLOSED;
            end
            release_pending(st, 1'b1);
            programs_done++;
            if (st != bfic_pkg::ST_OK) flagged_programs++;
            clear_program();
        end else if (prog_error == bfic_pkg::ST_OK) begin
            case (sym)
                bfic_pkg::CH_RIGHT: merge_run(bfic_pkg::OP_MOVE, 1'b1);
                bfic_pkg::CH_LEFT:  merge_run(bfic_pkg::OP_MOVE, 1'b0);
                bfic_pkg::CH_PLUS:  merge_run(bfic_pkg::OP_ADD, 1'b1);
                bfic_pkg::CH_MINUS: merge_run(bfic_pkg::OP_ADD, 1'b0);
                bfic_pkg::CH_DOT: begin
                    release_pending(prog_error, 1'b0);
                    cur_op = bfic_pkg::OP_OUT;
                end
                bfic_pkg::CH_COMMA: begin
                    release_pending(prog_error, 1'b0);
                    cur_op     = bfic_pkg::OP_IN;
                    want.load  = 1'b1;
                    want.store = 1'b0;
                end
                bfic_pkg::CH_OPEN: begin
                    if (open_depth >= NEST) begin
                        prog_error = bfic_pkg::ST_TOO_DEEP;
                    end else if (label_next == LABEL_LAST) begin
                        prog_error = bfic_pkg::ST_LABEL_OVF;
                    end else begin
                        release_pending(prog_error, 1'b0);
                        cur_op                  = bfic_pkg::OP_OPEN;
                        cur_label               = label_next;
                        open_labels[open_depth] = label_next;
                        open_depth++;
                        label_next++;
                    end
                end
                bfic_pkg::CH_CLOSE: begin
                    if (open_depth == 0) begin
                        prog_error = bfic_pkg::ST_UNMATCHED;
                    end else begin
                        release_pending(prog_error, 1'b0);
                        open_depth--;
                        cur_op    = bfic_pkg::OP_CLOSE;
                        cur_label = open_labels[open_depth];
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at %0t: expected %0h, got %0h (instruction %0d)",
                     what, $time, want_v, got_v, results_checked);
    endfunction

    function automatic void check_instr();
        t_instr e;
        if (expected_instrs.size() == 0) begin
            report_mismatch("unexpected instruction, op", '0, 32'(o_m_tuser));
            return;
        end
        e = expected_instrs.pop_front();
        results_checked++;
        if (o_m_tuser !== e.op) report_mismatch("op", 32'(e.op), 32'(o_m_tuser));
        if (o_m_tdata[AMT_W-1:0] !== e.amount)
            report_mismatch("amount", 32'($unsigned(e.amount)), 32'(o_m_tdata[AMT_W-1:0]));
        if (o_m_tdata[AMT_W +: LAB_W] !== e.label)
            report_mismatch("label", 32'(e.label), 32'(o_m_tdata[AMT_W +: LAB_W]));
        if (o_m_tdata[STORE_BIT] !== e.flags.store)
            report_mismatch("store_before", 32'(e.flags.store), 32'(o_m_tdata[STORE_BIT]));
        if (o_m_tdata[STORE_BIT+1] !== e.flags.reload)
            report_mismatch("reload_pointer", 32'(e.flags.reload),
                            32'(o_m_tdata[STORE_BIT+1]));
        if (o_m_tdata[STORE_BIT+2] !== e.flags.load)
            report_mismatch("load_after", 32'(e.flags.load), 32'(o_m_tdata[STORE_BIT+2]));
        if (o_m_tdata[STATUS_LSB +: bfic_pkg::STATUS_W] !== e.status)
            report_mismatch("status", 32'(e.status),
                            32'(o_m_tdata[STATUS_LSB +: bfic_pkg::STATUS_W]));
        if (o_m_tlast !== e.last) report_mismatch("last", 32'(e.last), 32'(o_m_tlast));
    endfunction

    // Check outgoing instructions before predicting, so same-edge traffic keeps queue order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) check_instr();
            if (i_s_tvalid && o_s_tready) coalesce_request(i_s_tdata, i_s_tlast);
        end
        if (sink_hold != 0) begin
            i_m_tready <= 1'b0;
            sink_hold  <= sink_hold - 1;
        end else begin
            i_m_tready <= 1'b1;
            if (sink_stalls) sink_hold <= pick_idle();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no request or instruction moved for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Entered and left right after a rising edge; valid stays high between back-to-back requests.
    task automatic send_request(input logic [SYM_W-1:0] sym, input logic endm);
        int gap;
        gap = src_gaps ? pick_idle() : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= sym;
        i_s_tlast  <= endm;
        do @(posedge i_clk); while (!o_s_tready);
        requests_sent++;
    endtask

    task automatic send_sym(input logic [SYM_W-1:0] sym);
        send_request(sym, 1'b0);
    endtask

    task automatic send_repeat(input logic [SYM_W-1:0] sym, input int count);
        repeat (count) send_request(sym, 1'b0);
    endtask

    // Symbol byte is don't-care with the end marker, so randomize it.
    task automatic end_program();
        send_request(SYM_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_instrs.size() != 0);
    endtask

    task automatic test_basic_programs();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        end_program();
        send_sym(8'h00);
        send_sym(bfic_pkg::CH_PLUS);
        send_sym(bfic_pkg::CH_PLUS);
        send_sym(bfic_pkg::CH_RIGHT);
        send_sym(8'hFF);
        send_sym(bfic_pkg::CH_MINUS);
        send_sym(bfic_pkg::CH_LEFT);
        send_sym(bfic_pkg::CH_DOT);
        send_sym(bfic_pkg::CH_COMMA);
        send_sym(bfic_pkg::CH_OPEN);
        send_sym(bfic_pkg::CH_MINUS);
        send_sym(bfic_pkg::CH_CLOSE);
        end_program();
        send_sym(bfic_pkg::CH_OPEN);
        send_sym(bfic_pkg::CH_DOT);
        end_program();
        // close with nothing open; everything after it is dropped
        send_sym(bfic_pkg::CH_DOT);
        send_sym(bfic_pkg::CH_CLOSE);
        send_sym(bfic_pkg::CH_PLUS);
        end_program();
        wait_for_results();
    endtask

    // Long runs in both directions that cross zero downward, at full input rate unless the sink stalls.
    task automatic test_amount_runs();
        src_gaps    = 1'b0;
        sink_stalls = 1'b1;
        send_repeat(bfic_pkg::CH_PLUS, 40);
        send_repeat(bfic_pkg::CH_MINUS, 45);
        send_sym(bfic_pkg::CH_RIGHT);
        send_repeat(bfic_pkg::CH_LEFT, 35);
        send_repeat(bfic_pkg::CH_RIGHT, 30);
        send_sym(bfic_pkg::CH_DOT);
        send_repeat(bfic_pkg::CH_MINUS, 3);
        send_sym(bfic_pkg::CH_PLUS);
        end_program();
        wait_for_results();
    endtask

    task automatic test_nesting_limit();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        send_repeat(bfic_pkg::CH_OPEN, NEST);
        send_sym(bfic_pkg::CH_COMMA);
        send_repeat(bfic_pkg::CH_CLOSE, NEST);
        end_program();
        send_repeat(bfic_pkg::CH_OPEN, NEST);
        send_sym(bfic_pkg::CH_OPEN);
        send_sym(bfic_pkg::CH_CLOSE);
        end_program();
        wait_for_results();
    endtask

    task automatic send_random_program();
        int  len;
        int  depth;
        int  roll;
        int  k;
        int  j;
        int  run;
        bit  broken;
        broken = ($urandom_range(0, 5) == 0);
        len    = $urandom_range(0, 24);
        depth  = 0;
        for (k = 0; k < len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                send_sym(SYM_W'($urandom_range(0, 255)));
            end else if (roll < 45) begin
                // runs mix both directions of one kind
                run = $urandom_range(1, 6);
                for (j = 0; j < run; j++) begin
                    if (roll < 27) begin
                        send_sym($urandom_range(0, 1) ? bfic_pkg::CH_PLUS : bfic_pkg::CH_MINUS);
                    end else begin
                        send_sym($urandom_range(0, 1) ? bfic_pkg::CH_RIGHT : bfic_pkg::CH_LEFT);
                    end
                end
            end else if (roll < 60) begin
                send_sym($urandom_range(0, 1) ? bfic_pkg::CH_DOT : bfic_pkg::CH_COMMA);
            end else if (roll < 80 || (depth == 0 && !broken)) begin
                send_sym(bfic_pkg::CH_OPEN);
                depth++;
            end else begin
                send_sym(bfic_pkg::CH_CLOSE);
                if (depth > 0) depth--;
            end
        end
        if (!broken) send_repeat(bfic_pkg::CH_CLOSE, depth);
        end_program();
    endtask

    task automatic test_random_programs();
        int start_count;
        bit paused;
        bit calm;
        start_count = requests_sent;
        paused      = 1'b0;
        while (requests_sent - start_count < RANDOM_ITEMS) begin
            calm        = ($urandom_range(0, 3) == 0);
            src_gaps    = !calm;
            sink_stalls = !calm;
            send_random_program();
            if (!paused && requests_sent - start_count > RANDOM_ITEMS / 2) begin
                wait_for_results();
                paused = 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        i_m_tready <= 1'b0;
        clear_program();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_programs();
        test_amount_runs();
        test_nesting_limit();
        test_random_programs();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests over %0d programs (%0d ended with a nonzero status),",
                 requests_sent, programs_done, flagged_programs);
        $display("checked %0d instructions, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0 && expected_instrs.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
